// ===== rtl/catmull_rom_to_bezier_stream_core_defines.svh =====
// Assertion helpers for the converter RTL, used by crb_seq.
`ifndef CATMULL_ROM_TO_BEZIER_STREAM_CORE_DEFINES_SVH
`define CATMULL_ROM_TO_BEZIER_STREAM_CORE_DEFINES_SVH

// Same-cycle implication, muted while in reset.
`define CRB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crb check failed");

// Next-cycle implication, muted while in reset.
`define CRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crb check failed");

`endif

// ===== rtl/crb_pkg.sv =====
package crb_pkg;

    // Coordinate format: signed fixed point, 16 fractional bits
    localparam int COORD_BITS = 32;
    localparam int CW         = COORD_BITS;
    localparam int TDATA_W    = ((2 * CW + 7) / 8) * 8;

    // Divide-by-six datapath widths
    localparam int SUM_W = CW + 3;                 // c + 6b - a, exact
    localparam int V_W   = CW + 3;                 // |sum| + 3
    localparam int U_W   = CW + 2;                 // (|sum| + 3) >> 1
    localparam int LO_W  = 2 * ((U_W + 2) / 4);    // even split, 2^LO_W == 1 mod 3
    localparam int HI_W  = U_W - LO_W;
    localparam int W_W   = ((HI_W > LO_W) ? HI_W : LO_W) + 1;
    localparam int K_W   = LO_W - 1;
    localparam int S_SH  = W_W + 2;
    localparam int R_W   = S_SH - 1;
    localparam int HP_W  = HI_W + K_W;
    localparam int WR_W  = W_W + R_W;

    // (2^LO_W - 1) / 3 and ceil(2^S_SH / 3)
    localparam logic [K_W-1:0] K_VAL = K_W'(((64'd1 << LO_W) - 64'd1) / 64'd3);
    localparam logic [R_W-1:0] R_VAL = R_W'(((64'd1 << S_SH) + 64'd2) / 64'd3);

    // Saturation limits on the quotient magnitude
    localparam logic [U_W-1:0] MAXV_Q   = U_W'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic [U_W-1:0] MINMAG_Q = U_W'(64'd1 << (CW - 1));

    // Arithmetic pipeline: sum, magnitude, split products, reciprocal, result
    localparam int PIPE_STAGES = 5;

    typedef logic signed [CW-1:0] coord_t;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_C1    = 2'd1,
        KIND_C2    = 2'd2,
        KIND_END   = 2'd3
    } kind_t;

    // One accepted point together with the history it sees
    typedef struct packed {
        logic   start;
        logic   seg_a;
        logic   seg_b;
        logic   last;
        coord_t h0x;
        coord_t h1x;
        coord_t h2x;
        coord_t qx;
        coord_t h0y;
        coord_t h1y;
        coord_t h2y;
        coord_t qy;
    } job_t;

    // One result to compute: value = round((c + 6b - a) / 6) per axis
    typedef struct packed {
        kind_t  kind;
        logic   done;
        coord_t ax;
        coord_t bx;
        coord_t cx;
        coord_t ay;
        coord_t by;
        coord_t cy;
    } op_t;

endpackage

// ===== rtl/crb_hist.sv =====
module crb_hist (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  crb_pkg::coord_t pt_x,
    input  crb_pkg::coord_t pt_y,
    input  logic           pt_last,
    output crb_pkg::job_t  job
);
    import crb_pkg::*;

    coord_t     hx_reg [3];
    coord_t     hy_reg [3];
    logic [1:0] seen_reg;
    logic [1:0] seen_next;

    // Work for the point on the port, seen against the current history
    always_comb
    begin
        job.start = (seen_reg == 2'd0);
        job.seg_a = (seen_reg == 2'd2);
        job.seg_b = pt_last && (seen_reg != 2'd0);
        job.last  = pt_last;
        job.h0x   = hx_reg[0];
        job.h1x   = hx_reg[1];
        job.h2x   = hx_reg[2];
        job.qx    = pt_x;
        job.h0y   = hy_reg[0];
        job.h1y   = hy_reg[1];
        job.h2y   = hy_reg[2];
        job.qy    = pt_y;
    end

    // Points seen: 0 idle, 1 after the path start, 2 once segments flow
    always_comb
    begin
        if (pt_last)
            seen_next = 2'd0;
        else if (seen_reg == 2'd0)
            seen_next = 2'd1;
        else
            seen_next = 2'd2;
    end

    // History: fill on the first point, shift afterwards
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hx_reg[i] <= '0;
                hy_reg[i] <= '0;
            end
            seen_reg <= 2'd0;
        end
        else if (accept)
        begin
            if (seen_reg == 2'd0)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    hx_reg[i] <= pt_x;
                    hy_reg[i] <= pt_y;
                end
            end
            else
            begin
                hx_reg[0] <= hx_reg[1];
                hx_reg[1] <= hx_reg[2];
                hx_reg[2] <= pt_x;
                hy_reg[0] <= hy_reg[1];
                hy_reg[1] <= hy_reg[2];
                hy_reg[2] <= pt_y;
            end
            seen_reg <= seen_next;
        end
    end

endmodule

// ===== rtl/crb_seq.sv =====
`include "catmull_rom_to_bezier_stream_core_defines.svh"

module crb_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  crb_pkg::job_t job,
    output logic          issue_valid,
    input  logic          issue_ready,
    output crb_pkg::op_t  op
);
    import crb_pkg::*;

    typedef enum logic [6:0] {
        STEP_START = 7'b0000001,
        STEP_A_C1  = 7'b0000010,
        STEP_A_C2  = 7'b0000100,
        STEP_A_END = 7'b0001000,
        STEP_B_C1  = 7'b0010000,
        STEP_B_C2  = 7'b0100000,
        STEP_B_END = 7'b1000000
    } step_t;

    job_t  job_reg;
    logic  busy_reg;
    logic  busy_next;
    step_t step_reg;
    step_t step_next;
    step_t step_first;
    logic  last_step;
    logic  load;
    logic  has_results;

    // Last result of the held item
    assign last_step = (step_reg == STEP_START) || (step_reg == STEP_B_END)
                    || ((step_reg == STEP_A_END) && !job_reg.seg_b);

    // Take the next item when idle or as the final result of this one leaves
    assign in_ready    = !busy_reg || (issue_ready && last_step);
    assign load        = in_valid && in_ready;
    assign has_results = job.start || job.seg_a || job.seg_b;
    assign issue_valid = busy_reg;

    always_comb
    begin
        if (job.start)
            step_first = STEP_START;
        else if (job.seg_a)
            step_first = STEP_A_C1;
        else
            step_first = STEP_B_C1;
    end

    // Step order through the results of one item
    always_comb
    begin
        unique case (step_reg)
            STEP_A_C1:  step_next = STEP_A_C2;
            STEP_A_C2:  step_next = STEP_A_END;
            STEP_A_END: step_next = STEP_B_C1;
            STEP_B_C1:  step_next = STEP_B_C2;
            STEP_B_C2:  step_next = STEP_B_END;
            default:    step_next = STEP_START;
        endcase
    end

    always_comb
    begin
        if (load)
            busy_next = has_results;
        else if (issue_ready && last_step)
            busy_next = 1'b0;
        else
            busy_next = busy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_START;
        end
        else
        begin
            busy_reg <= busy_next;
            if (load)
                step_reg <= step_first;
            else if (busy_reg && issue_ready)
                step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            job_reg <= job;
    end

    // Operands per step; end points and the path start go through as 6v / 6
    always_comb
    begin
        op.kind = KIND_START;
        op.done = 1'b0;
        op.ax   = '0;
        op.bx   = job_reg.qx;
        op.cx   = '0;
        op.ay   = '0;
        op.by   = job_reg.qy;
        op.cy   = '0;
        unique case (step_reg)
            STEP_START:
            begin
                op.done = job_reg.last;
            end
            STEP_A_C1:
            begin
                op.kind = KIND_C1;
                op.ax   = job_reg.h0x;
                op.bx   = job_reg.h1x;
                op.cx   = job_reg.h2x;
                op.ay   = job_reg.h0y;
                op.by   = job_reg.h1y;
                op.cy   = job_reg.h2y;
            end
            STEP_A_C2:
            begin
                op.kind = KIND_C2;
                op.ax   = job_reg.qx;
                op.bx   = job_reg.h2x;
                op.cx   = job_reg.h1x;
                op.ay   = job_reg.qy;
                op.by   = job_reg.h2y;
                op.cy   = job_reg.h1y;
            end
            STEP_A_END:
            begin
                op.kind = KIND_END;
                op.bx   = job_reg.h2x;
                op.by   = job_reg.h2y;
            end
            STEP_B_C1:
            begin
                op.kind = KIND_C1;
                op.ax   = job_reg.h1x;
                op.bx   = job_reg.h2x;
                op.cx   = job_reg.qx;
                op.ay   = job_reg.h1y;
                op.by   = job_reg.h2y;
                op.cy   = job_reg.qy;
            end
            STEP_B_C2:
            begin
                op.kind = KIND_C2;
                op.ax   = job_reg.qx;
                op.cx   = job_reg.h2x;
                op.ay   = job_reg.qy;
                op.cy   = job_reg.h2y;
            end
            STEP_B_END:
            begin
                op.kind = KIND_END;
                op.done = 1'b1;
            end
            default:
            begin
                op.kind = KIND_START;
            end
        endcase
    end

    `CRB_ASSERT_IMPL(a_ready_at_end, clk, rst_n, busy_reg && in_ready, issue_ready && last_step)
    `CRB_ASSERT_IMPL(a_step_onehot, clk, rst_n, busy_reg, $onehot(step_reg))
    `CRB_ASSERT_IMPL(a_close_on_last, clk, rst_n, busy_reg && job_reg.seg_b, job_reg.last)
    `CRB_ASSERT_NEXT(a_hold_step, clk, rst_n, busy_reg && !issue_ready, busy_reg && $stable(step_reg))

endmodule

// ===== rtl/crb_div6.sv =====
module crb_div6 (
    input  logic                              clk,
    input  logic [crb_pkg::PIPE_STAGES-1:0]   en,
    input  crb_pkg::coord_t                   op_a,
    input  crb_pkg::coord_t                   op_b,
    input  crb_pkg::coord_t                   op_c,
    output crb_pkg::coord_t                   res
);
    import crb_pkg::*;

    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] mag_s;
    logic [U_W-1:0]          u_val;
    logic [HI_W-1:0]         uhi_reg;
    logic [LO_W-1:0]         ulo_reg;
    logic                    neg1_reg;
    logic [HP_W-1:0]         hp_reg;
    logic [W_W-1:0]          w_reg;
    logic                    neg2_reg;
    logic [HP_W-1:0]         hp3_reg;
    logic [WR_W-1:0]         wr_reg;
    logic                    neg3_reg;
    logic [U_W-1:0]          q_val;
    coord_t                  res_next;
    coord_t                  res_reg;

    // Exact control sum c + 6b - a
    assign sum_next = SUM_W'(op_c) + (SUM_W'(op_b) <<< 2) + (SUM_W'(op_b) <<< 1)
                    - SUM_W'(op_a);

    // Magnitude plus half the divisor, then halved: q = floor(u / 3)
    assign mag_s = sum_reg[SUM_W-1] ? (SUM_W'(3) - sum_reg) : (sum_reg + SUM_W'(3));
    assign u_val = mag_s[V_W-1:1];

    // u = hi * 2^LO_W + lo, and 2^LO_W - 1 divides by 3
    assign q_val = U_W'(hp3_reg) + U_W'(wr_reg[WR_W-1:S_SH]);

    // Restore sign and saturate
    always_comb
    begin
        if (!neg3_reg && (q_val > MAXV_Q))
            res_next = {1'b0, {(CW - 1){1'b1}}};
        else if (neg3_reg && (q_val > MINMAG_Q))
            res_next = {1'b1, {(CW - 1){1'b0}}};
        else if (neg3_reg)
            res_next = -q_val[CW-1:0];
        else
            res_next = q_val[CW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            sum_reg <= sum_next;
        if (en[1])
        begin
            uhi_reg  <= u_val[U_W-1:LO_W];
            ulo_reg  <= u_val[LO_W-1:0];
            neg1_reg <= sum_reg[SUM_W-1];
        end
        if (en[2])
        begin
            hp_reg   <= HP_W'(uhi_reg) * HP_W'(K_VAL);
            w_reg    <= W_W'(uhi_reg) + W_W'(ulo_reg);
            neg2_reg <= neg1_reg;
        end
        if (en[3])
        begin
            hp3_reg  <= hp_reg;
            wr_reg   <= WR_W'(w_reg) * WR_W'(R_VAL);
            neg3_reg <= neg2_reg;
        end
        if (en[4])
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== rtl/catmull_rom_to_bezier_stream_core.sv =====
// Throughput: one result per cycle through a 5-stage divide-by-six pipeline,
// stalled while m_axis_tready holds back the output; the next item is taken as
// the last result of the current one enters the pipeline. An item has 3 results
// for an inner point or the final point of a two-point stroke, 6 for any other
// final point, 1 for a path start, none for a point that yields nothing.
// Reset (rst_n, async, active low) clears the history, the point count and all valids.
module catmull_rom_to_bezier_stream_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [crb_pkg::TDATA_W-1:0]  s_axis_tdata,  // point_x, point_y, zero pad
    input  logic                         s_axis_tlast,  // stroke_end
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [crb_pkg::TDATA_W-1:0]  m_axis_tdata,  // out_x, out_y, zero pad
    output logic [1:0]                   m_axis_tuser,  // point_kind
    output logic                         m_axis_tlast   // stroke_done
);
    import crb_pkg::*;

    job_t                   job;
    op_t                    op;
    logic                   issue_valid;
    logic                   issue_ready;
    logic [PIPE_STAGES-1:0] en;
    logic [PIPE_STAGES-1:0] vld_reg;
    kind_t                  kind_reg [PIPE_STAGES];
    logic                   done_reg [PIPE_STAGES];
    coord_t                 res_x;
    coord_t                 res_y;

    crb_hist u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (s_axis_tvalid && s_axis_tready),
        .pt_x    (s_axis_tdata[CW-1:0]),
        .pt_y    (s_axis_tdata[2*CW-1:CW]),
        .pt_last (s_axis_tlast),
        .job     (job)
    );

    crb_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .job         (job),
        .issue_valid (issue_valid),
        .issue_ready (issue_ready),
        .op          (op)
    );

    // Stage enables: a stage moves when empty or when the one after moves
    always_comb
    begin
        en[PIPE_STAGES-1] = !vld_reg[PIPE_STAGES-1] || m_axis_tready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    assign issue_ready = en[0];

    crb_div6 u_div_x (
        .clk  (clk),
        .en   (en),
        .op_a (op.ax),
        .op_b (op.bx),
        .op_c (op.cx),
        .res  (res_x)
    );

    crb_div6 u_div_y (
        .clk  (clk),
        .en   (en),
        .op_a (op.ay),
        .op_b (op.by),
        .op_c (op.cy),
        .res  (res_y)
    );

    // Valid bits alongside the arithmetic
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= issue_valid;
            for (int k = 1; k < PIPE_STAGES; k++)
            begin
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Kind and stroke-done tags follow each result
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            kind_reg[0] <= op.kind;
            done_reg[0] <= op.done;
        end
        for (int k = 1; k < PIPE_STAGES; k++)
        begin
            if (en[k])
            begin
                kind_reg[k] <= kind_reg[k-1];
                done_reg[k] <= done_reg[k-1];
            end
        end
    end

    assign m_axis_tvalid = vld_reg[PIPE_STAGES-1];
    assign m_axis_tdata  = TDATA_W'({res_y, res_x});
    assign m_axis_tuser  = kind_reg[PIPE_STAGES-1];
    assign m_axis_tlast  = done_reg[PIPE_STAGES-1];

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import crb_pkg::*;

    localparam int     RAND_POINTS    = 480;
    localparam int     LONG_HOLD      = 400;
    localparam int     HOLD_AFTER     = 400;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     TAIL_CYCLES    = 20;
    localparam longint COORD_MAX      = (longint'(1) <<< (CW - 1)) - 1;
    localparam longint COORD_MIN      = -COORD_MAX - 1;
    localparam coord_t P_MAX          = coord_t'(COORD_MAX);
    localparam coord_t N_MIN          = coord_t'(COORD_MIN);

    // One emitted curve point
    typedef struct packed {
        kind_t  kind;
        coord_t x;
        coord_t y;
        logic   done;
    } curve_pt_t;

    // Directed stimulus row; want is only used when typed is set
    typedef struct packed {
        coord_t    x;
        coord_t    y;
        logic      last;
        logic      typed;
        curve_pt_t want;
    } stim_row_t;

    localparam curve_pt_t NO_WANT = '{KIND_START, '0, '0, 1'b0};

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    // Predictor state
    coord_t     hist_x [3];
    coord_t     hist_y [3];
    logic [1:0] pts_seen;

    curve_pt_t  bezier_q [$];
    int         errors        = 0;
    int         clamp_count   = 0;
    int         points_sent   = 0;
    int         strokes_sent  = 0;
    int         results_seen  = 0;
    int         rx_stall      = 0;
    int         rx_cycles     = 0;
    int         rx_pick       = 0;
    int         quiet_cycles  = 0;
    int         last_added    = 0;
    bit         long_hold_used = 1'b0;

    catmull_rom_to_bezier_stream_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Divide by six, round half away from zero, clamp to the coordinate range
    function automatic coord_t div6_round_sat(longint s);
        longint q;
        if (s < 0)
            q = -((-s + 3) / 6);
        else
            q = (s + 3) / 6;
        if (q > COORD_MAX)
        begin
            clamp_count++;
            return P_MAX;
        end
        if (q < COORD_MIN)
        begin
            clamp_count++;
            return N_MIN;
        end
        return coord_t'(q);
    endfunction

    // c1, c2 and end point of the segment through hist[1] -> hist[2]
    function automatic void emit_segment(coord_t qx, coord_t qy, logic done);
        coord_t c1x, c1y, c2x, c2y;
        c1x = div6_round_sat(-longint'(hist_x[0]) + 6 * longint'(hist_x[1])
                             + longint'(hist_x[2]));
        c1y = div6_round_sat(-longint'(hist_y[0]) + 6 * longint'(hist_y[1])
                             + longint'(hist_y[2]));
        c2x = div6_round_sat(longint'(hist_x[1]) + 6 * longint'(hist_x[2]) - longint'(qx));
        c2y = div6_round_sat(longint'(hist_y[1]) + 6 * longint'(hist_y[2]) - longint'(qy));
        bezier_q.push_back('{KIND_C1, c1x, c1y, 1'b0});
        bezier_q.push_back('{KIND_C2, c2x, c2y, 1'b0});
        bezier_q.push_back('{KIND_END, hist_x[2], hist_y[2], done});
    endfunction

    // Curve points caused by one stroke point
    function automatic void convert_point(coord_t qx, coord_t qy, logic last);
        if (pts_seen == 2'd0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hist_x[i] = qx;
                hist_y[i] = qy;
            end
            bezier_q.push_back('{KIND_START, qx, qy, last});
            pts_seen = last ? 2'd0 : 2'd1;
        end
        else
        begin
            if (pts_seen == 2'd2)
                emit_segment(qx, qy, 1'b0);
            hist_x[0] = hist_x[1];
            hist_x[1] = hist_x[2];
            hist_x[2] = qx;
            hist_y[0] = hist_y[1];
            hist_y[1] = hist_y[2];
            hist_y[2] = qy;
            pts_seen  = 2'd2;
            if (last)
            begin
                emit_segment(qx, qy, 1'b1);
                pts_seen = 2'd0;
            end
        end
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    // Random walk near the previous point, extremes, or fully random
    function automatic coord_t pick_coord(coord_t prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return prev + coord_t'(int'($urandom_range(0, 1048575)) - 524288);
        if (r < 62)
        begin
            case ($urandom_range(0, 3))
                0:       return P_MAX;
                1:       return N_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        return coord_t'($urandom);
    endfunction

    // Offer one point after an optional gap; returns at its acceptance edge
    task automatic send_point(coord_t x, coord_t y, logic last, int gap);
        int n_pre;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'({y, x});
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        points_sent++;
        if (last)
            strokes_sent++;
        // Count what this point adds at the back of the queue
        n_pre = bezier_q.size();
        convert_point(x, y, last);
        last_added = bezier_q.size() - n_pre;
    endtask

    // Stop offering and wait until every expected curve point has arrived
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (bezier_q.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, quiet windows and one long hold-off
    always @(posedge clk)
    begin
        rx_cycles <= rx_cycles + 1;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (rx_stall > 0)
            rx_stall <= rx_stall - 1;
        else if (!long_hold_used && results_seen >= HOLD_AFTER)
        begin
            long_hold_used <= 1'b1;
            rx_stall       <= LONG_HOLD - 1;
            m_axis_tready  <= 1'b0;
        end
        else if ((rx_cycles / 256) % 4 == 0)
            m_axis_tready <= 1'b1;
        else
        begin
            rx_pick = idle_len();
            if (rx_pick == 0)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                rx_stall      <= rx_pick - 1;
            end
        end
    end

    // Compare each curve point with the oldest expectation
    always @(posedge clk)
    begin : result_check
        curve_pt_t want;
        coord_t    gx;
        coord_t    gy;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen <= results_seen + 1;
            gx = m_axis_tdata[CW-1:0];
            gy = m_axis_tdata[2*CW-1:CW];
            if (bezier_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected curve point: kind %0d x %0d y %0d done %0d",
                             m_axis_tuser, gx, gy, m_axis_tlast);
            end
            else
            begin
                want = bezier_q.pop_front();
                if (m_axis_tuser !== want.kind || gx !== want.x || gy !== want.y
                    || m_axis_tlast !== want.done)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: want kind %0d x %0d y %0d done %0d, got %0d %0d %0d %0d",
                                 want.kind, want.x, want.y, want.done,
                                 m_axis_tuser, gx, gy, m_axis_tlast);
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles, %0d still expected",
                     quiet_cycles, bezier_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t rows [$];
        stim_row_t row_now;
        coord_t    wx;
        coord_t    wy;
        int        len;
        int        r;
        int        rand_sent;
        bit        quiet;
        bit        paused;

        hist_x    = '{default: '0};
        hist_y    = '{default: '0};
        pts_seen  = 2'd0;
        wx        = '0;
        wy        = '0;
        rand_sent = 0;
        paused    = 1'b0;

        // Single-point strokes: path start only, flagged as done
        rows.push_back('{'0, '0, 1'b1, 1'b1, '{KIND_START, '0, '0, 1'b1}});
        rows.push_back('{P_MAX, N_MIN, 1'b1, 1'b1, '{KIND_START, P_MAX, N_MIN, 1'b1}});
        rows.push_back('{N_MIN, P_MAX, 1'b1, 1'b1, '{KIND_START, N_MIN, P_MAX, 1'b1}});
        // Two-point stroke: closing segment only
        rows.push_back('{32'sh0001_0000, -32'sh0001_0000, 1'b0, 1'b1,
                         '{KIND_START, 32'sh0001_0000, -32'sh0001_0000, 1'b0}});
        rows.push_back('{32'sh0003_0000, 32'sh0002_0000, 1'b1, 1'b0, NO_WANT});
        // Clamp at the negative limit, second point silent
        rows.push_back('{N_MIN, N_MIN, 1'b0, 1'b1, '{KIND_START, N_MIN, N_MIN, 1'b0}});
        rows.push_back('{N_MIN, N_MIN, 1'b0, 1'b0, NO_WANT});
        rows.push_back('{P_MAX, P_MAX, 1'b1, 1'b0, NO_WANT});
        // Clamp at the positive limit
        rows.push_back('{P_MAX, P_MAX, 1'b0, 1'b1, '{KIND_START, P_MAX, P_MAX, 1'b0}});
        rows.push_back('{P_MAX, P_MAX, 1'b0, 1'b0, NO_WANT});
        rows.push_back('{N_MIN, N_MIN, 1'b1, 1'b0, NO_WANT});
        // Rounding ties away from zero, alternating bit patterns
        rows.push_back('{'0, '0, 1'b0, 1'b1, '{KIND_START, '0, '0, 1'b0}});
        rows.push_back('{'0, '0, 1'b0, 1'b0, NO_WANT});
        rows.push_back('{32'sd3, -32'sd3, 1'b0, 1'b0, NO_WANT});
        rows.push_back('{32'sd9, -32'sd9, 1'b0, 1'b0, NO_WANT});
        rows.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, NO_WANT});
        rows.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, NO_WANT});
        rows.push_back('{'1, 32'sd1, 1'b1, 1'b0, NO_WANT});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; typed rows replace the predicted path start
        foreach (rows[i])
        begin
            row_now = rows[i];
            send_point(row_now.x, row_now.y, row_now.last, idle_len());
            if (row_now.typed)
            begin
                repeat (last_added)
                    void'(bezier_q.pop_back());
                bezier_q.push_back(row_now.want);
            end
        end
        wait_for_drain();

        // Random strokes, mostly moderate length
        while (rand_sent < RAND_POINTS)
        begin
            quiet = (strokes_sent % 4 == 0);
            r     = $urandom_range(0, 99);
            if (r < 15)
                len = 1;
            else if (r < 30)
                len = 2;
            else if (r < 88)
                len = $urandom_range(3, 12);
            else
                len = $urandom_range(13, 40);
            for (int k = 0; k < len; k++)
            begin
                if (!paused && rand_sent >= RAND_POINTS / 2)
                begin
                    wait_for_drain();
                    paused = 1'b1;
                end
                wx = pick_coord(wx);
                wy = pick_coord(wy);
                send_point(wx, wy, k == len - 1, quiet ? 0 : idle_len());
                rand_sent++;
            end
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d points in %0d strokes, %0d curve points checked",
                 points_sent, strokes_sent, results_seen);
        $display("%0d control values clamped, receiver long hold-off %0s",
                 clamp_count, long_hold_used ? "done" : "not reached");
        if (errors == 0 && bezier_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/crb_pkg.sv
rtl/crb_hist.sv
rtl/crb_seq.sv
rtl/crb_div6.sv
rtl/catmull_rom_to_bezier_stream_core.sv
test/tb_top.sv
